/* rtl/qcrd_pkg.sv */
// Package for the QPSK carrier-recovery de-rotator: widths, sine ROM, register indexes, ALU op codes.
// No dependencies.
`timescale 1ns / 1ps
package qcrd_pkg;
    localparam int FRAME_POINTS_DEF = 256;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_DECIMATION = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_ON    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_ON   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_GAIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_GAIN  = 3'd4;

    // ALU operation codes for the shared multiply unit
    typedef enum logic [2:0] {
        OP_MUL = 3'd0,
        OP_MAC = 3'd1,
        OP_MSB = 3'd2
    } t_alu_op;

    function automatic logic signed [7:0] quarter_sine(input logic [6:0] r);
        logic signed [7:0] v;
        case (r)
            7'd0: v = 8'sd0;     7'd1: v = 8'sd3;     7'd2: v = 8'sd6;     7'd3: v = 8'sd9;
            7'd4: v = 8'sd12;    7'd5: v = 8'sd16;    7'd6: v = 8'sd19;    7'd7: v = 8'sd22;
            7'd8: v = 8'sd25;    7'd9: v = 8'sd28;    7'd10: v = 8'sd31;   7'd11: v = 8'sd34;
            7'd12: v = 8'sd37;   7'd13: v = 8'sd40;   7'd14: v = 8'sd43;   7'd15: v = 8'sd46;
            7'd16: v = 8'sd49;   7'd17: v = 8'sd51;   7'd18: v = 8'sd54;   7'd19: v = 8'sd57;
            7'd20: v = 8'sd60;   7'd21: v = 8'sd63;   7'd22: v = 8'sd65;   7'd23: v = 8'sd68;
            7'd24: v = 8'sd71;   7'd25: v = 8'sd73;   7'd26: v = 8'sd76;   7'd27: v = 8'sd78;
            7'd28: v = 8'sd81;   7'd29: v = 8'sd83;   7'd30: v = 8'sd85;   7'd31: v = 8'sd88;
            7'd32: v = 8'sd90;   7'd33: v = 8'sd92;   7'd34: v = 8'sd94;   7'd35: v = 8'sd96;
            7'd36: v = 8'sd98;   7'd37: v = 8'sd100;  7'd38: v = 8'sd102;  7'd39: v = 8'sd104;
            7'd40: v = 8'sd106;  7'd41: v = 8'sd107;  7'd42: v = 8'sd109;  7'd43: v = 8'sd111;
            7'd44: v = 8'sd112;  7'd45: v = 8'sd113;  7'd46: v = 8'sd115;  7'd47: v = 8'sd116;
            7'd48: v = 8'sd117;  7'd49: v = 8'sd118;  7'd50: v = 8'sd120;  7'd51: v = 8'sd121;
            7'd52: v = 8'sd122;  7'd53: v = 8'sd122;  7'd54: v = 8'sd123;  7'd55: v = 8'sd124;
            7'd56: v = 8'sd125;  7'd57: v = 8'sd125;  7'd58: v = 8'sd126;  7'd59: v = 8'sd126;
            7'd60: v = 8'sd126;  7'd61: v = 8'sd127;  7'd62: v = 8'sd127;  7'd63: v = 8'sd127;
            default: v = 8'sd127;
        endcase
        return v;
    endfunction

    function automatic logic signed [7:0] sine_rom(input logic [7:0] idx);
        logic [6:0] r;
        logic [6:0] rr;
        logic signed [7:0] v;
        r  = {1'b0, idx[5:0]};
        rr = 7'd64 - r;
        case (idx[7:6])
            2'd0: v = quarter_sine(r);
            2'd1: v = quarter_sine(rr);
            2'd2: v = -quarter_sine(r);
            default: v = -quarter_sine(rr);
        endcase
        return v;
    endfunction
endpackage

/* rtl/qcrd_mul.sv */
// Shared signed multiply/accumulate unit: 34x34 product registered, one op a cycle while i_en is high.
// Depends on qcrd_pkg.
`timescale 1ns / 1ps
module qcrd_mul (
    input  logic                i_clk,
    input  logic                i_en,
    input  qcrd_pkg::t_alu_op   i_op,
    input  logic signed [33:0]  i_a,
    input  logic signed [33:0]  i_b,
    output logic signed [67:0]  o_acc
);
    logic signed [67:0] w_prod;
    logic signed [67:0] r_acc;
    logic signed [67:0] n_acc;

    assign w_prod = 68'(i_a) * 68'(i_b);

    always_comb begin
        case (i_op)
            qcrd_pkg::OP_MAC: n_acc = r_acc + w_prod;
            qcrd_pkg::OP_MSB: n_acc = r_acc - w_prod;
            default:          n_acc = w_prod;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;
endmodule

/* rtl/qcrd_isqrt.sv */
// Truncated 2^24/sqrt(m2): one result bit per cycle, x*x*m2 <= 2^48 test.
// Depends on nothing but its inputs.
`timescale 1ns / 1ps
module qcrd_isqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_m2,
    output logic        o_done,
    output logic [24:0] o_inv
);
    logic [24:0] r_x;
    logic [24:0] r_bit;
    logic [65:0] r_p;   // x*x*m2
    logic [65:0] r_a;   // 2*x*m2*bit
    logic [65:0] r_b;   // m2*bit*bit
    logic        r_busy;
    logic        r_done;
    logic [65:0] w_t;

    // (x+bit)^2*m2 = x*x*m2 + 2*x*m2*bit + m2*bit*bit; bit sits below every set bit of x,
    // so each term follows from the last by shifts and one add
    assign w_t = r_p + r_a + r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_x    <= '0;
                r_bit  <= 25'h1000000;
                r_p    <= '0;
                r_a    <= '0;
                r_b    <= {2'b00, i_m2, 48'd0};
            end else if (r_busy) begin
                if (w_t <= (66'd1 << 48)) begin
                    r_x <= r_x | r_bit;
                    r_p <= w_t;
                    r_a <= (r_a >> 1) + r_b;
                end else begin
                    r_a <= r_a >> 1;
                end
                r_b   <= r_b >> 2;
                r_bit <= r_bit >> 1;
                if (r_bit[0]) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_inv  = r_x;
endmodule

/* rtl/qpsk_carrier_recovery_derotator_unit.sv */
// Top level of the QPSK carrier-recovery de-rotator: sequencer, loop state, ports.
// Depends on qcrd_pkg, qcrd_mul, qcrd_isqrt.
//
//  channel | dir | handshake                  | payload
//  s_axis  | in  | s_axis_tvalid/tready       | tdata[7:0]=i_sample, [15:8]=q_sample
//  m_axis  | out | m_axis_tvalid/tready/tlast | tdata[7:0]=point_i, [15:8]=point_q
//  cfg     | in  | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// A skipped word only bumps the skip count. A kept word skips the loop maths with both
// loops off or a tiny magnitude; with a loop on, the loop maths runs through one shared
// multiplier and a bit-serial inverse square root of 25 steps. A finished point waits
// until the output register is empty or being read; input is taken only while idle, so
// a stalled output holds the next word off.
// Synchronous active-low reset; no clearing pass.
`timescale 1ns / 1ps
module qpsk_carrier_recovery_derotator_unit #(
    parameter int FRAME_POINTS = qcrd_pkg::FRAME_POINTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [15:0]                       s_axis_tdata,  // i_sample, q_sample
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [15:0]                       m_axis_tdata,  // point_i, point_q
    output logic                              m_axis_tlast,
    input  logic                              i_cfg_we,
    input  logic [qcrd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [qcrd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    localparam int PCW = $clog2(FRAME_POINTS + 1);

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_ROT  = 10'b0000000010,
        S_MUL  = 10'b0000000100,
        S_SQRT = 10'b0000001000,
        S_NORM = 10'b0000010000,
        S_SQ   = 10'b0000100000,
        S_PLL  = 10'b0001000000,
        S_FLL  = 10'b0010000000,
        S_FADD = 10'b0100000000,
        S_OUT  = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    logic [3:0] r_step, n_step;

    // configuration
    logic [15:0]        r_dec;
    logic               r_fon, r_pon;
    logic signed [31:0] r_pgain, r_fgain;

    // loop state
    logic [15:0]        r_skip;
    logic [31:0]        r_phase, r_offset;
    logic signed [31:0] r_freq;
    logic signed [17:0] r_lr, r_li;
    logic               r_have;
    logic [PCW-1:0]     r_pcount;

    // working values
    logic signed [7:0]  r_iv, r_qv, r_sin, r_cos;
    logic signed [33:0] r_di, r_dq, r_ni, r_nq, r_r2, r_i2, r_r4, r_i4, r_err;

    // output register
    logic        r_ovalid, r_olast;
    logic [15:0] r_odata;

    // shared multiplier
    logic               w_men;
    qcrd_pkg::t_alu_op  w_op;
    logic signed [33:0] w_a, w_b;
    logic signed [67:0] w_acc;

    qcrd_mul u_mul (
        .i_clk(i_clk), .i_en(w_men), .i_op(w_op),
        .i_a(w_a), .i_b(w_b), .o_acc(w_acc)
    );

    // m2 is in the accumulator on the cycle the root is started
    logic        w_sqs, w_sqdone;
    logic [24:0] w_inv;
    qcrd_isqrt u_isqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_sqs), .i_m2(w_acc[15:0]),
        .o_done(w_sqdone), .o_inv(w_inv)
    );

    logic        w_in_acc;
    logic [15:0] w_last;
    logic [31:0] w_angle;
    logic [7:0]  w_idx;
    logic        w_oempty;

    assign w_oempty      = !r_ovalid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_last        = (r_dec == 16'd0) ? 16'd0 : r_dec - 16'd1;
    assign w_angle       = r_phase + r_offset;
    assign w_idx         = w_angle[31:24];

    function automatic logic [7:0] clampb(input logic signed [33:0] v);
        logic [7:0] o;
        if (v < -34'sd128)     o = 8'd0;
        else if (v > 34'sd127) o = 8'd255;
        else                   o = v[7:0] + 8'd128;
        return o;
    endfunction

    // multiplier operand selection and next state per state/step
    always_comb begin
        w_men = 1'b0;
        w_op  = qcrd_pkg::OP_MUL;
        w_a   = '0;
        w_b   = '0;
        w_sqs = 1'b0;
        n_state = r_state;
        n_step  = r_step + 4'd1;
        case (r_state)
            S_IDLE: begin
                n_step = '0;
                if (w_in_acc && r_skip >= w_last) n_state = S_ROT;
            end
            S_ROT: begin
                n_state = S_MUL;
                n_step  = '0;
            end
            S_MUL: begin
                // di = iv*c + qv*s; dq = qv*c - iv*s; m2 = di^2+dq^2
                w_men = 1'b1;
                case (r_step)
                    4'd0: begin w_a = 34'(r_iv); w_b = 34'(r_cos); end
                    4'd1: begin w_op = qcrd_pkg::OP_MAC; w_a = 34'(r_qv); w_b = 34'(r_sin); end
                    4'd2: begin w_a = 34'(r_qv); w_b = 34'(r_cos); end
                    4'd3: begin w_op = qcrd_pkg::OP_MSB; w_a = 34'(r_iv); w_b = 34'(r_sin); end
                    4'd4: begin w_a = r_di; w_b = r_di; end
                    4'd5: begin w_op = qcrd_pkg::OP_MAC; w_a = r_dq; w_b = r_dq; end
                    default: begin
                        w_men = 1'b0;
                        if ((r_fon || r_pon) && w_acc > 68'sd1) begin
                            n_state = S_SQRT;
                            w_sqs   = 1'b1;
                        end else begin
                            n_state = S_OUT;
                        end
                    end
                endcase
            end
            S_SQRT: begin
                n_step = '0;
                if (w_sqdone) n_state = S_NORM;
            end
            S_NORM: begin
                w_men = 1'b1;
                case (r_step)
                    4'd0: begin w_a = r_di; w_b = 34'($signed({1'b0, w_inv})); end
                    4'd1: begin w_a = r_dq; w_b = 34'($signed({1'b0, w_inv})); end
                    4'd2: w_men = 1'b0;
                    default: begin w_men = 1'b0; n_state = S_SQ; n_step = '0; end
                endcase
            end
            S_SQ: begin
                w_men = 1'b1;
                case (r_step)
                    4'd0: begin w_a = r_ni; w_b = r_ni; end
                    4'd1: begin w_op = qcrd_pkg::OP_MSB; w_a = r_nq; w_b = r_nq; end
                    4'd2: begin w_a = r_ni; w_b = r_nq; end
                    4'd3: begin w_a = r_r2; w_b = r_r2; end
                    4'd4: begin w_op = qcrd_pkg::OP_MSB; w_a = r_i2; w_b = r_i2; end
                    4'd5: begin w_a = r_r2; w_b = r_i2; end
                    4'd6: w_men = 1'b0;
                    default: begin w_men = 1'b0; n_state = S_PLL; n_step = '0; end
                endcase
            end
            S_PLL: begin
                w_men = 1'b1;
                case (r_step)
                    4'd0: begin w_a = 34'(r_pgain); w_b = r_i4; end
                    4'd1: begin w_a = 34'(r_lr); w_b = r_i4; end
                    4'd2: begin w_op = qcrd_pkg::OP_MSB; w_a = 34'(r_li); w_b = r_r4; end
                    default: begin w_men = 1'b0; n_state = S_FLL; n_step = '0; end
                endcase
            end
            S_FLL: begin
                w_men = 1'b1;
                w_a = 34'(r_fgain);
                w_b = r_err;
                n_state = S_FADD;
            end
            S_FADD: n_state = S_OUT;
            S_OUT: begin
                n_step = '0;
                if (w_oempty) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    logic signed [33:0] w_f;
    assign w_f = 34'(r_freq) + 34'(w_acc >>> 16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= '0;
            r_dec    <= 16'd1;
            r_fon    <= 1'b0;
            r_pon    <= 1'b0;
            r_pgain  <= '0;
            r_fgain  <= '0;
            r_skip   <= '0;
            r_phase  <= '0;
            r_freq   <= '0;
            r_offset <= '0;
            r_lr     <= '0;
            r_li     <= '0;
            r_have   <= 1'b0;
            r_pcount <= '0;
            r_ovalid <= 1'b0;
            r_olast  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    qcrd_pkg::REG_DECIMATION: r_dec   <= i_cfg_data[15:0];
                    qcrd_pkg::REG_FREQ_ON:    r_fon   <= i_cfg_data[0];
                    qcrd_pkg::REG_PHASE_ON:   r_pon   <= i_cfg_data[0];
                    qcrd_pkg::REG_PHASE_GAIN: r_pgain <= i_cfg_data;
                    qcrd_pkg::REG_FREQ_GAIN:  r_fgain <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: if (w_in_acc) begin
                    if (r_skip < w_last) begin
                        r_skip <= r_skip + 16'd1;
                    end else begin
                        r_skip  <= '0;
                        r_iv    <= s_axis_tdata[7:0];
                        r_qv    <= s_axis_tdata[15:8];
                        r_phase <= r_phase + r_freq;
                    end
                end
                S_ROT: begin
                    r_sin <= qcrd_pkg::sine_rom(w_idx);
                    r_cos <= qcrd_pkg::sine_rom(w_idx + 8'd64);
                end
                S_MUL: begin
                    if (r_step == 4'd2) r_di <= 34'(w_acc >>> 7);
                    if (r_step == 4'd4) r_dq <= 34'(w_acc >>> 7);
                end
                S_NORM: begin
                    if (r_step == 4'd1) r_ni <= 34'(w_acc >>> 8);
                    if (r_step == 4'd2) r_nq <= 34'(w_acc >>> 8);
                end
                S_SQ: begin
                    if (r_step == 4'd2) r_r2 <= 34'(w_acc >>> 16);
                    if (r_step == 4'd3) r_i2 <= 34'(w_acc >>> 15);
                    if (r_step == 4'd5) r_r4 <= 34'(w_acc >>> 16);
                    if (r_step == 4'd6) r_i4 <= 34'(w_acc >>> 15);
                end
                S_PLL: begin
                    if (r_step == 4'd1 && r_pon) r_offset <= r_offset + w_acc[47:16];
                    if (r_step == 4'd3) r_err <= 34'(w_acc >>> 16);
                end
                S_FADD: begin
                    if (r_fon && r_have) begin
                        if (w_f < -34'sd1073741824)     r_freq <= -32'sd1073741824;
                        else if (w_f > 34'sd1073741824) r_freq <= 32'sd1073741824;
                        else                            r_freq <= w_f[31:0];
                    end
                    r_lr   <= r_r4[17:0];
                    r_li   <= r_i4[17:0];
                    r_have <= 1'b1;
                end
                S_OUT: if (w_oempty) begin
                    r_ovalid <= 1'b1;
                    r_odata  <= {clampb(r_dq), clampb(r_di)};
                    if (r_pcount + PCW'(1) >= PCW'(FRAME_POINTS)) begin
                        r_pcount <= '0;
                        r_olast  <= 1'b1;
                    end else begin
                        r_pcount <= r_pcount + PCW'(1);
                        r_olast  <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;
endmodule

/* rtl/qcrd_checker.sv */
// Port-level checker for the de-rotator, bound to the top level.
// Depends on qpsk_carrier_recovery_derotator_unit.
`timescale 1ns / 1ps
module qcrd_port_props (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    // an output word stalled must hold
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
        else $error("output word changed under stall");

    // no output after reset
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // a rising output valid needs the input side busy (s_axis_tready low) now or just before
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !s_axis_tready || $past(!s_axis_tready))
        else $error("output word without input");
endmodule

bind qpsk_carrier_recovery_derotator_unit qcrd_port_props u_qcrd_port_props (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);

/* bench/qcrd_checker.sv */
// Checker for the QPSK carrier-recovery de-rotator: watches the input, output and
// register write channels, predicts each output word and compares. Depends on qcrd_pkg.
`timescale 1ns / 1ps
module qcrd_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [15:0]                     s_axis_tdata,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [15:0]                     m_axis_tdata,
    input  logic                            m_axis_tlast,
    input  logic                            i_cfg_we,
    input  logic [qcrd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [qcrd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_points_seen,
    output int                              o_frames_seen
);
    localparam int FRAME_LEN = qcrd_pkg::FRAME_POINTS_DEF;

    typedef struct packed {
        logic [7:0] point_i;
        logic [7:0] point_q;
        logic       frame_end;
    } t_point;

    localparam int QUARTER [65] = '{
        0, 3, 6, 9, 12, 16, 19, 22, 25, 28, 31, 34, 37, 40, 43, 46,
        49, 51, 54, 57, 60, 63, 65, 68, 71, 73, 76, 78, 81, 83, 85, 88,
        90, 92, 94, 96, 98, 100, 102, 104, 106, 107, 109, 111, 112, 113, 115, 116,
        117, 118, 120, 121, 122, 122, 123, 124, 125, 125, 126, 126, 126, 127, 127, 127,
        127
    };

    // register copies
    logic [15:0]        decim;
    logic               fll_on, pll_on;
    logic signed [31:0] phase_gain, freq_gain;
    // loop state
    int                 skip_cnt;
    logic [31:0]        phase_acc, phase_offs;
    longint             freq_word;
    longint             prev_r4, prev_i4;
    logic               prev_valid;
    int                 frame_pos;

    t_point expected_points [$];

    function automatic longint sin_q7(input logic [7:0] idx);
        int r;
        r = idx[5:0];
        case (idx[7:6])
            2'd0: return QUARTER[r];
            2'd1: return QUARTER[64 - r];
            2'd2: return -QUARTER[r];
            default: return -QUARTER[64 - r];
        endcase
    endfunction

    // truncated 2^24 / sqrt(m2), bit by bit from the top
    function automatic longint inv_sqrt_q24(input longint m2);
        longint unsigned lim, x, cand;
        lim = (64'd1 << 48) / longint'(m2);
        x = 0;
        for (int b = 24; b >= 0; b--) begin
            cand = x | (64'd1 << b);
            if (cand * cand <= lim) x = cand;
        end
        return longint'(x);
    endfunction

    function automatic logic [7:0] to_offset_binary(input longint v);
        if (v < -128) v = -128;
        if (v > 127) v = 127;
        return 8'(v + 128);
    endfunction

    task automatic derotate_sample(input logic signed [7:0] si, input logic signed [7:0] sq);
        int          keep_every;
        logic [31:0] angle;
        logic [7:0]  idx;
        longint      s, c, iv, qv, di, dq, m2, inv, ni, nq, r2, i2, r4, i4, d, err, f;
        t_point      p;
        keep_every = (decim == 0) ? 1 : int'(decim);
        if (skip_cnt < keep_every - 1) begin
            skip_cnt++;
            return;
        end
        skip_cnt = 0;
        iv = si;
        qv = sq;
        phase_acc = phase_acc + freq_word[31:0];
        angle = phase_acc + phase_offs;
        idx = angle[31:24];
        s = sin_q7(idx);
        c = sin_q7(idx + 8'd64);
        di = (iv * c + qv * s) >>> 7;
        dq = (qv * c - iv * s) >>> 7;
        if (fll_on || pll_on) begin
            m2 = di * di + dq * dq;
            if (m2 > 1) begin
                inv = inv_sqrt_q24(m2);
                ni = (di * inv) >>> 8;
                nq = (dq * inv) >>> 8;
                r2 = (ni * ni - nq * nq) >>> 16;
                i2 = (ni * nq) >>> 15;
                r4 = (r2 * r2 - i2 * i2) >>> 16;
                i4 = (r2 * i2) >>> 15;
                if (pll_on) begin
                    d = (longint'(phase_gain) * i4) >>> 16;
                    phase_offs = phase_offs + d[31:0];
                end
                if (fll_on && prev_valid) begin
                    err = (prev_r4 * i4 - prev_i4 * r4) >>> 16;
                    f = freq_word + ((longint'(freq_gain) * err) >>> 16);
                    if (f < -(64'sd1 << 30)) f = -(64'sd1 << 30);
                    if (f > (64'sd1 << 30)) f = 64'sd1 << 30;
                    freq_word = f;
                end
                prev_r4 = r4;
                prev_i4 = i4;
                prev_valid = 1'b1;
            end
        end
        p.point_i = to_offset_binary(di);
        p.point_q = to_offset_binary(dq);
        frame_pos++;
        p.frame_end = (frame_pos >= FRAME_LEN);
        if (p.frame_end) frame_pos = 0;
        expected_points.push_back(p);
    endtask

    initial begin
        o_fail_count = 0;
        o_points_seen = 0;
        o_frames_seen = 0;
    end

    always @(posedge i_clk) begin
        t_point exp_p;
        if (!i_rst_n) begin
            decim = 16'd1;
            fll_on = 1'b0;
            pll_on = 1'b0;
            phase_gain = '0;
            freq_gain = '0;
            skip_cnt = 0;
            phase_acc = '0;
            phase_offs = '0;
            freq_word = 0;
            prev_r4 = 0;
            prev_i4 = 0;
            prev_valid = 1'b0;
            frame_pos = 0;
            expected_points.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    qcrd_pkg::REG_DECIMATION: decim = i_cfg_data[15:0];
                    qcrd_pkg::REG_FREQ_ON:    fll_on = i_cfg_data[0];
                    qcrd_pkg::REG_PHASE_ON:   pll_on = i_cfg_data[0];
                    qcrd_pkg::REG_PHASE_GAIN: phase_gain = i_cfg_data;
                    qcrd_pkg::REG_FREQ_GAIN:  freq_gain = i_cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                derotate_sample(s_axis_tdata[7:0], s_axis_tdata[15:8]);
            if (m_axis_tvalid && m_axis_tready) begin
                o_points_seen++;
                if (m_axis_tlast) o_frames_seen++;
                if (expected_points.size() == 0) begin
                    $error("output word with nothing expected: tdata=%h tlast=%b",
                           m_axis_tdata, m_axis_tlast);
                    o_fail_count++;
                end else begin
                    exp_p = expected_points.pop_front();
                    if (m_axis_tdata[7:0] !== exp_p.point_i) begin
                        $error("point_i: expected %0d, got %0d", exp_p.point_i,
                               m_axis_tdata[7:0]);
                        o_fail_count++;
                    end
                    if (m_axis_tdata[15:8] !== exp_p.point_q) begin
                        $error("point_q: expected %0d, got %0d", exp_p.point_q,
                               m_axis_tdata[15:8]);
                        o_fail_count++;
                    end
                    if (m_axis_tlast !== exp_p.frame_end) begin
                        $error("frame_end: expected %0b, got %0b", exp_p.frame_end,
                               m_axis_tlast);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = expected_points.size();
    end
endmodule

/* bench/tb_qpsk_carrier_recovery_derotator_unit.sv */
// Testbench top for the QPSK carrier-recovery de-rotator: clock, reset, stimulus and
// verdict. Depends on qcrd_pkg, qcrd_checker and the block itself.
`timescale 1ns / 1ps
module tb_qpsk_carrier_recovery_derotator_unit;
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;  // i_sample, q_sample
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;       // point_i, point_q
    logic        m_axis_tlast;
    logic                            i_cfg_we = 1'b0;
    logic [qcrd_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [qcrd_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    int fail_count, pending, points_seen, frames_seen;
    int words_sent = 0;
    bit quiet = 0;      // no idling on either side
    bit long_hold = 0;  // receiver holds off for a long stretch

    always #6 i_clk = ~i_clk;

    qpsk_carrier_recovery_derotator_unit DUT (.*);

    qcrd_checker u_checker (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending),
        .o_points_seen(points_seen), .o_frames_seen(frames_seen)
    );

    // receiver side
    initial begin
        forever begin
            if (long_hold) begin
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
                long_hold = 0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic send_sample(input logic [7:0] si, input logic [7:0] sq);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {sq, si};
        do @(posedge i_clk); while (!s_axis_tready);
        words_sent++;
    endtask

    // sender pauses until every point is out, then leaves some slack
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [qcrd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_loops(input logic [15:0] dec, input bit fll, input bit pll,
                             input logic [31:0] pgain, input logic [31:0] fgain);
        drain();
        write_reg(qcrd_pkg::REG_DECIMATION, {16'd0, dec});
        write_reg(qcrd_pkg::REG_FREQ_ON, {31'd0, fll});
        write_reg(qcrd_pkg::REG_PHASE_ON, {31'd0, pll});
        write_reg(qcrd_pkg::REG_PHASE_GAIN, pgain);
        write_reg(qcrd_pkg::REG_FREQ_GAIN, fgain);
    endtask

    // mostly QPSK-like points of varied amplitude with jitter, some tiny, some raw noise
    task automatic random_burst(input int n);
        logic [7:0] a, b;
        int amp, kind;
        for (int k = 0; k < n; k++) begin
            kind = $urandom_range(0, 9);
            if (kind < 6) begin
                amp = $urandom_range(20, 127);
                a = $urandom_range(0, 1) ? 8'(amp) : 8'(-amp);
                b = 8'(int'($urandom_range(0, 1) ? amp : -amp) + int'($urandom_range(0, 30)) - 15);
            end else if (kind < 8) begin
                a = 8'($urandom_range(0, 255));
                b = 8'($urandom_range(0, 255));
            end else begin
                a = 8'(int'($urandom_range(0, 2)) - 1);
                b = 8'(int'($urandom_range(0, 2)) - 1);
            end
            send_sample(a, b);
        end
    endtask

    function automatic logic [31:0] rand_gain();
        logic [31:0] g;
        g = $urandom_range(1 << 14, 1 << 24);
        return $urandom_range(0, 1) ? g : -g;
    endfunction

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes with loops off
        send_sample(8'h80, 8'h80);
        send_sample(8'h7f, 8'h7f);
        send_sample(8'h80, 8'h7f);
        send_sample(8'h7f, 8'h80);
        send_sample(8'h00, 8'h00);
        send_sample(8'h01, 8'h00);
        send_sample(8'hff, 8'hff);
        send_sample(8'h55, 8'haa);
        // decimation of zero keeps every word; tiny magnitude leaves loops alone
        set_loops(16'd0, 1, 1, 32'h7fff_ffff, 32'h8000_0000);
        send_sample(8'h01, 8'h00);
        send_sample(8'h00, 8'hff);
        send_sample(8'h60, 8'h60);
        send_sample(8'h90, 8'h50);
        send_sample(8'h7f, 8'h81);
        send_sample(8'h40, 8'hc0);
        // largest decimation, then lowered below the skip count
        set_loops(16'hffff, 1, 1, 32'h8000_0000, 32'h7fff_ffff);
        send_sample(8'h10, 8'h20);
        send_sample(8'h30, 8'h40);
        send_sample(8'h50, 8'h60);
        set_loops(16'd2, 1, 1, 32'h8000_0000, 32'h7fff_ffff);
        send_sample(8'h70, 8'h10);
        send_sample(8'hc0, 8'h40);
        send_sample(8'h40, 8'h40);

        set_loops(16'd1, 0, 1, rand_gain(), 32'd0);
        random_burst(300);
        set_loops(16'd1, 1, 0, 32'd0, rand_gain());
        random_burst(150);
        long_hold = 1;  // receiver holds off while words keep coming
        random_burst(150);
        set_loops(16'd3, 1, 1, rand_gain(), rand_gain());
        random_burst(300);
        set_loops(16'd1, 1, 1, 32'h7fff_ffff, 32'h7fff_ffff);
        random_burst(250);
        set_loops(16'd2, 0, 0, rand_gain(), rand_gain());
        random_burst(250);
        set_loops(16'd1, 1, 1, rand_gain(), rand_gain());
        quiet = 1;
        random_burst(380);

        drain();
        repeat (100) @(posedge i_clk);
        $display("run: %0d input words, %0d points, %0d frame ends, loops and decimation",
                 words_sent, points_seen, frames_seen);
        $display("settings swept incl. gain extremes and decimation 0 and 65535");
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("timeout");
        $display("end of test: mismatches");
        $finish;
    end
endmodule
